// ===== rtl/core/jsu_pkg.sv =====
package jsu_pkg;

    // Result kinds
    localparam logic [2:0] KIND_RAW     = 3'd0;
    localparam logic [2:0] KIND_CP      = 3'd1;
    localparam logic [2:0] KIND_END     = 3'd2;
    localparam logic [2:0] KIND_UNTERM  = 3'd3;
    localparam logic [2:0] KIND_BADHEX  = 3'd4;

    // Characters and surrogate ranges
    localparam logic [7:0]  CHAR_QUOTE     = 8'h22;
    localparam logic [7:0]  CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0]  CHAR_N         = 8'h6e;
    localparam logic [7:0]  CHAR_T         = 8'h74;
    localparam logic [7:0]  CHAR_U         = 8'h75;
    localparam logic [15:0] HIGH_FIRST     = 16'hd800;
    localparam logic [15:0] HIGH_LAST      = 16'hdbff;
    localparam logic [15:0] LOW_FIRST      = 16'hdc00;
    localparam logic [15:0] LOW_LAST       = 16'hdfff;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;

    // Parser mode
    typedef enum logic [3:0] {
        M_NORMAL   = 4'd0,
        M_ESC      = 4'd1,
        M_HEX1_0   = 4'd2,
        M_HEX1_1   = 4'd3,
        M_HEX1_2   = 4'd4,
        M_HEX1_3   = 4'd5,
        M_HELD     = 4'd6,
        M_HELD_ESC = 4'd7,
        M_HEX2_0   = 4'd8,
        M_HEX2_1   = 4'd9,
        M_HEX2_2   = 4'd10,
        M_HEX2_3   = 4'd11
    } mode_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [20:0] value;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.digit = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.digit = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.digit = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.digit = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Escape other than \u: n and t map to control codes, rest pass literally
    function automatic res_t plain_escape(input logic [7:0] c);
        res_t r;
        r.last = 1'b0;
        if (c == CHAR_N) begin
            r.kind  = KIND_CP;
            r.value = 21'd10;
        end else if (c == CHAR_T) begin
            r.kind  = KIND_CP;
            r.value = 21'd9;
        end else begin
            r.kind  = KIND_RAW;
            r.value = {13'd0, c};
        end
        return r;
    endfunction

    function automatic res_t make_res(input logic [2:0] kind, input logic [20:0] value);
        res_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/json_string_unescape.sv =====
// JSON string unescaper. Feed the string body one byte per beat, starting after
// the opening quote, with first_byte set on the first byte of each string. Each
// byte yields zero, one or two result beats (raw byte, escaped code point, end,
// unterminated, bad hex); last_of_run marks the final beat of a byte. A held
// high surrogate is merged with a following low-surrogate \u escape. One input
// byte is taken per clock while the output is ready, and results drain at one per
// clock; a byte that yields two results occupies the two-entry result buffer and
// stalls the input until the first of them is taken. After an error or end of
// string, bytes are dropped until the next first_byte.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [20:0] m_value,
    output logic        m_last_of_run
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc1_reg, acc1_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] acc2_reg, acc2_next;
    logic        halted_reg, halted_next;

    res_t        slot0_reg, slot0_next;
    res_t        slot1_reg, slot1_next;
    logic        slot0_valid_reg, slot0_valid_next;
    logic        slot1_valid_reg, slot1_valid_next;

    mode_t       mode_cur;
    logic [15:0] acc1_cur, held_cur, acc2_cur;
    logic        halted_cur;
    logic [1:0]  num_res;
    res_t        res0, res1;
    hex_t        hex;
    logic [15:0] acc1_new, acc2_new;
    logic        s_fire;

    assign s_ready = !slot1_valid_reg && (!slot0_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    // Effective state: a first byte starts from a cleared, unhalted state
    always_comb begin
        mode_cur   = s_first_byte ? M_NORMAL : mode_reg;
        acc1_cur   = s_first_byte ? 16'd0 : acc1_reg;
        held_cur   = s_first_byte ? 16'd0 : held_reg;
        acc2_cur   = s_first_byte ? 16'd0 : acc2_reg;
        halted_cur = s_first_byte ? 1'b0 : halted_reg;
    end

    assign hex      = hex_decode(s_data_byte);
    assign acc1_new = {acc1_cur[11:0], hex.digit};
    assign acc2_new = {acc2_cur[11:0], hex.digit};

    // Decode one byte into next state and up to two results
    always_comb begin
        mode_next   = mode_cur;
        acc1_next   = acc1_cur;
        held_next   = held_cur;
        acc2_next   = acc2_cur;
        halted_next = halted_cur;
        num_res     = 2'd0;
        res0        = make_res(KIND_RAW, 21'd0);
        res1        = make_res(KIND_RAW, 21'd0);
        if (!halted_cur) begin
            if (s_final_byte && !(s_data_byte == CHAR_QUOTE
                                  && (mode_cur == M_NORMAL || mode_cur == M_HELD))) begin
                res0        = make_res(KIND_UNTERM, 21'd0);
                num_res     = 2'd1;
                halted_next = 1'b1;
                mode_next   = M_NORMAL;
            end else begin
                case (mode_cur)
                    M_NORMAL: begin
                        if (s_data_byte == CHAR_QUOTE) begin
                            res0        = make_res(KIND_END, 21'd0);
                            num_res     = 2'd1;
                            halted_next = 1'b1;
                        end else if (s_data_byte == CHAR_BACKSLASH) begin
                            mode_next = M_ESC;
                        end else begin
                            res0    = make_res(KIND_RAW, {13'd0, s_data_byte});
                            num_res = 2'd1;
                        end
                    end
                    M_ESC: begin
                        if (s_data_byte == CHAR_U) begin
                            acc1_next = 16'd0;
                            mode_next = M_HEX1_0;
                        end else begin
                            res0      = plain_escape(s_data_byte);
                            num_res   = 2'd1;
                            mode_next = M_NORMAL;
                        end
                    end
                    M_HEX1_0, M_HEX1_1, M_HEX1_2, M_HEX1_3: begin
                        if (!hex.ok) begin
                            res0        = make_res(KIND_BADHEX, 21'd0);
                            num_res     = 2'd1;
                            halted_next = 1'b1;
                            mode_next   = M_NORMAL;
                        end else begin
                            acc1_next = acc1_new;
                            if (mode_cur == M_HEX1_3) begin
                                if (acc1_new >= HIGH_FIRST && acc1_new <= HIGH_LAST) begin
                                    held_next = acc1_new;
                                    mode_next = M_HELD;
                                end else begin
                                    res0      = make_res(KIND_CP, {5'd0, acc1_new});
                                    num_res   = 2'd1;
                                    mode_next = M_NORMAL;
                                end
                            end else begin
                                mode_next = mode_t'(4'(mode_cur + 4'd1));
                            end
                        end
                    end
                    M_HELD: begin
                        if (s_data_byte == CHAR_BACKSLASH) begin
                            mode_next = M_HELD_ESC;
                        end else begin
                            res0    = make_res(KIND_CP, {5'd0, held_cur});
                            num_res = 2'd2;
                            if (s_data_byte == CHAR_QUOTE) begin
                                res1        = make_res(KIND_END, 21'd0);
                                halted_next = 1'b1;
                            end else begin
                                res1 = make_res(KIND_RAW, {13'd0, s_data_byte});
                            end
                            mode_next = M_NORMAL;
                        end
                    end
                    M_HELD_ESC: begin
                        if (s_data_byte == CHAR_U) begin
                            acc2_next = 16'd0;
                            mode_next = M_HEX2_0;
                        end else begin
                            res0      = make_res(KIND_CP, {5'd0, held_cur});
                            res1      = plain_escape(s_data_byte);
                            num_res   = 2'd2;
                            mode_next = M_NORMAL;
                        end
                    end
                    M_HEX2_0, M_HEX2_1, M_HEX2_2, M_HEX2_3: begin
                        if (!hex.ok) begin
                            res0        = make_res(KIND_CP, {5'd0, held_cur});
                            res1        = make_res(KIND_BADHEX, 21'd0);
                            num_res     = 2'd2;
                            halted_next = 1'b1;
                            mode_next   = M_NORMAL;
                        end else begin
                            acc2_next = acc2_new;
                            if (mode_cur == M_HEX2_3) begin
                                if (acc2_new >= LOW_FIRST && acc2_new <= LOW_LAST) begin
                                    // merge surrogate pair
                                    res0 = make_res(KIND_CP,
                                        SUPP_BASE + {1'b0, held_cur[9:0], acc2_new[9:0]});
                                    num_res   = 2'd1;
                                    mode_next = M_NORMAL;
                                end else begin
                                    res0 = make_res(KIND_CP, {5'd0, held_cur});
                                    if (acc2_new >= HIGH_FIRST && acc2_new <= HIGH_LAST) begin
                                        held_next = acc2_new;
                                        num_res   = 2'd1;
                                        mode_next = M_HELD;
                                    end else begin
                                        res1      = make_res(KIND_CP, {5'd0, acc2_new});
                                        num_res   = 2'd2;
                                        mode_next = M_NORMAL;
                                    end
                                end
                            end else begin
                                mode_next = mode_t'(4'(mode_cur + 4'd1));
                            end
                        end
                    end
                    default: begin
                        mode_next = M_NORMAL;
                    end
                endcase
            end
        end
        res0.last = (num_res == 2'd1);
        res1.last = 1'b1;
    end

    // Result buffer: slot0 drives the output, slot1 holds a second result
    always_comb begin
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        slot0_valid_next = slot0_valid_reg;
        slot1_valid_next = slot1_valid_reg;
        if (s_fire) begin
            slot0_next       = res0;
            slot1_next       = res1;
            slot0_valid_next = (num_res != 2'd0);
            slot1_valid_next = (num_res == 2'd2);
        end else if (slot0_valid_reg && m_ready) begin
            slot0_next       = slot1_reg;
            slot0_valid_next = slot1_valid_reg;
            slot1_valid_next = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_NORMAL;
            acc1_reg   <= 16'd0;
            held_reg   <= 16'd0;
            acc2_reg   <= 16'd0;
            halted_reg <= 1'b1;
        end else if (s_fire) begin
            mode_reg   <= mode_next;
            acc1_reg   <= acc1_next;
            held_reg   <= held_next;
            acc2_reg   <= acc2_next;
            halted_reg <= halted_next;
        end
    end

    // Result buffer valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end else begin
            slot0_valid_reg <= slot0_valid_next;
            slot1_valid_reg <= slot1_valid_next;
        end
    end

    // Result buffer payload
    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_valid       = slot0_valid_reg;
    assign m_kind        = slot0_reg.kind;
    assign m_value       = slot0_reg.value;
    assign m_last_of_run = slot0_reg.last;

endmodule
